### hw/rtl/symmetric_fir_q15_macros.svh
// assertion macros for the symmetric fir block
`ifndef SYMMETRIC_FIR_Q15_MACROS_SVH
`define SYMMETRIC_FIR_Q15_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, muted while reset is low
`define SFIR_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sfir: same-cycle check failed");
// next-cycle implication, muted while reset is low
`define SFIR_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sfir: next-cycle check failed");
`else
`define SFIR_ASSERT_IMP(label, clk, rst_n, pre, post)
`define SFIR_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

### hw/rtl/sfir_pkg.sv
// shared types and constants for the symmetric fir block
package sfir_pkg;

    // sample and coefficient word, q15 two's complement
    typedef logic signed [15:0] t_sample;

    // accumulator: only bits 30..15 of the exact sum are kept, so mod 2^31 suffices
    localparam int ACC_W = 31;
    typedef logic [ACC_W-1:0] t_acc;

    // output bit position of the q15 shift
    localparam int SHIFT_Q15 = 15;

    // coefficient register file
    localparam int NCOEF   = 8;
    localparam int COEF_IW = $clog2(NCOEF);
    typedef t_sample t_coef_arr [NCOEF];

    // apb register map: one 32-bit word per coefficient
    localparam int ADDR_LSB = 2;
    localparam int ADDR_W   = ADDR_LSB + COEF_IW;
    localparam int DATA_W   = 32;

    // coefficient values after reset
    localparam t_coef_arr COEF_RESET = '{
        16'sd0 - 16'sd1586, 16'sd1037, 16'sd2173, 16'sd528,
        16'sd0 - 16'sd2496, 16'sd0 - 16'sd1370, 16'sd6023, 16'sd13670
    };

endpackage

### hw/rtl/sfir_cell.sv
// delay line cell: one stored sample, handed to the next cell on each request
module sfir_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_shift,
    input  logic             i_restart,
    input  sfir_pkg::t_sample i_din,
    output sfir_pkg::t_sample o_tap,
    output sfir_pkg::t_sample o_q
);
    import sfir_pkg::*;

    t_sample r_d;

    // history register, shifts only when a request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= '0;
        end else if (i_shift) begin
            r_d <= i_din;
        end
    end

    // restart masks the history seen by this request and by the next cell
    assign o_tap = i_restart ? t_sample'(0) : r_d;
    assign o_q   = r_d;

endmodule

### hw/rtl/sfir_mac.sv
// symmetric tap pair: pre-add, multiply by shared coefficient, register
module sfir_mac (
    input  logic              i_clk,
    input  logic              i_en,
    input  sfir_pkg::t_sample i_coef,
    input  sfir_pkg::t_sample i_a,
    input  sfir_pkg::t_sample i_b,
    output sfir_pkg::t_acc    o_prod
);
    import sfir_pkg::*;

    logic signed [16:0] w_pre;
    logic signed [32:0] w_prod;
    t_acc               r_prod;

    // both samples share one coefficient, so add them first
    assign w_pre  = 17'(i_a) + 17'(i_b);
    assign w_prod = 33'(i_coef) * 33'(w_pre);

    // product kept modulo 2^31, which is all the output needs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_prod[ACC_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/sfir_tree.sv
// registered binary adder tree over the lane products
module sfir_tree #(
    parameter int LEAVES = 8
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  sfir_pkg::t_acc i_leaf [LEAVES],
    output sfir_pkg::t_acc o_root
);
    import sfir_pkg::*;

    localparam int NODES = 2 * LEAVES - 1;

    // heap order: node i has children 2i+1 and 2i+2, leaves at the end
    t_acc w_node [NODES];

    genvar j;
    generate
        for (j = 0; j < LEAVES; j++) begin : g_leaf
            assign w_node[LEAVES-1+j] = i_leaf[j];
        end

        // one register per inner node, so every level is one stage
        for (j = 0; j < LEAVES - 1; j++) begin : g_node
            t_acc r_sum;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sum <= t_acc'(w_node[2*j+1] + w_node[2*j+2]);
                end
            end
            assign w_node[j] = r_sum;
        end
    endgenerate

    assign o_root = w_node[0];

endmodule

### hw/rtl/symmetric_fir_q15.sv
// symmetric fir filter top level: delay cells, tap pair lanes, adder tree, apb registers
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------------------
//  input    | i_in_valid / o_in_ready       | i_sample_in, i_restart
//  output   | o_out_valid / i_out_ready     | o_sample_out
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  one request per clock while the output is not held; a result passes through
//  the lane multiply stage and then the adder tree levels
//  reset clears the delay line and pipeline valids and loads the default
//  coefficients; no clearing pass is needed
//  a held result at the output freezes the whole pipeline and drops o_in_ready
`include "symmetric_fir_q15_macros.svh"

module symmetric_fir_q15 #(
    parameter int TAPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample requests
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  sfir_pkg::t_sample                   i_sample_in,
    input  logic                                i_restart,
    // filtered samples
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output sfir_pkg::t_sample                   o_sample_out,
    // coefficient registers
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sfir_pkg::ADDR_W-1:0]         paddr,
    input  logic [sfir_pkg::DATA_W-1:0]         pwdata,
    output logic [sfir_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import sfir_pkg::*;

    localparam int NCELL  = TAPS - 1;
    localparam int NL     = (TAPS + 1) / 2;
    localparam int LEVELS = $clog2(NL);
    localparam int LEAVES = 1 << LEVELS;
    localparam int STAGES = LEVELS + 1;

    t_sample              r_coef [NCOEF];
    logic [STAGES-1:0]    r_valid;
    logic [STAGES-1:0]    n_valid;
    logic                 w_adv;
    logic                 w_in_acc;
    logic                 w_cfg_wr;
    logic [COEF_IW-1:0]   w_cfg_idx;
    t_sample              w_win  [TAPS];
    t_sample              w_q    [NCELL];
    logic [NCELL-1:0]     w_hist_nz;
    t_acc                 w_leaf [LEAVES];
    t_acc                 w_root;

    // apb coefficient registers
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = paddr[ADDR_W-1:ADDR_LSB];
    assign prdata    = DATA_W'(r_coef[w_cfg_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (w_cfg_wr) begin
            r_coef[w_cfg_idx] <= pwdata[15:0];
        end
    end

    // pipeline advance: moves whenever the output stage is free or drained
    assign w_adv      = !r_valid[STAGES-1] || i_out_ready;
    assign o_in_ready = w_adv;
    assign w_in_acc   = i_in_valid && w_adv;

    always_comb begin
        n_valid = r_valid;
        if (w_adv) begin
            n_valid[0] = i_in_valid;
            for (int s = 1; s < STAGES; s++) begin
                n_valid[s] = r_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // delay line: chain of cells, the window of this request is w_win
    assign w_win[0] = i_sample_in;

    genvar k;
    generate
        for (k = 0; k < NCELL; k++) begin : g_cell
            sfir_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_shift   (w_in_acc),
                .i_restart (i_restart),
                .i_din     (w_win[k]),
                .o_tap     (w_win[k+1]),
                .o_q       (w_q[k])
            );
            if (k == 0) begin : g_first
                assign w_hist_nz[k] = 1'b0;
            end else begin : g_rest
                assign w_hist_nz[k] = (w_q[k] != t_sample'(0));
            end
        end

        // one lane per shared coefficient; the middle tap of an odd length stands alone
        for (k = 0; k < NL; k++) begin : g_lane
            t_sample w_b;
            if (k != TAPS - 1 - k) begin : g_pair
                assign w_b = w_win[TAPS-1-k];
            end else begin : g_mid
                assign w_b = t_sample'(0);
            end
            sfir_mac u_mac (
                .i_clk  (i_clk),
                .i_en   (w_adv),
                .i_coef (r_coef[k]),
                .i_a    (w_win[k]),
                .i_b    (w_b),
                .o_prod (w_leaf[k])
            );
        end

        // unused tree leaves
        for (k = NL; k < LEAVES; k++) begin : g_pad
            assign w_leaf[k] = t_acc'(0);
        end
    endgenerate

    // sum of lane products
    sfir_tree #(
        .LEAVES (LEAVES)
    ) u_tree (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_leaf (w_leaf),
        .o_root (w_root)
    );

    // q15 shift and wrap: bits 30..15 of the sum
    assign o_out_valid  = r_valid[STAGES-1];
    assign o_sample_out = w_root[ACC_W-1:SHIFT_Q15];

    // checks
    `SFIR_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    `SFIR_ASSERT_NXT(a_request_enters_pipe, i_clk, i_rst_n, w_in_acc, r_valid[0])
    `SFIR_ASSERT_NXT(a_restart_clears_history, i_clk, i_rst_n, w_in_acc && i_restart, w_hist_nz == '0)

endmodule

### tb/tb_symmetric_fir_q15.sv
`timescale 1ns / 1ps
// self-checking testbench for the symmetric 16-tap q15 fir filter
module tb_symmetric_fir_q15;
    import sfir_pkg::*;

    localparam int NUM_TAPS         = 16;
    localparam int HOLD_CYCLES      = 400;
    localparam int STALL_LIMIT      = 2000;
    localparam int RAND_PHASE_ITEMS = 300;
    localparam int DRAIN_CYCLES     = 8;

    typedef struct packed {
        t_sample sample;
        logic    restart;
    } t_fir_request;

    typedef enum {CS_DEFAULT, CS_ALL_MIN, CS_ALL_MAX, CS_ALTERNATE, CS_RANDOM} t_coef_set;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_sample           i_sample_in = '0;
    logic              i_restart   = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_sample           o_sample_out;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // pending sample requests and the filtered samples they should produce
    t_fir_request sample_requests[$];
    t_sample      filtered_expected[$];

    // predictor state: coefficient copy and delay line, newest first
    t_sample coef_shadow[NCOEF] = COEF_RESET;
    t_sample history[NUM_TAPS-1];

    int   requests_open  = 0;
    int   mismatch_count = 0;
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    int   holds_asked    = 0;
    int   holds_done     = 0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;
    logic req_taken      = 1'b0;

    symmetric_fir_q15 #(.TAPS(NUM_TAPS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        foreach (history[k]) history[k] = '0;
    end

    // one filter step: returns bits 30..15 of the exact tap sum, then shifts the history
    function automatic t_sample fir_filter_next(t_sample x, logic restart);
        longint  acc;
        t_sample s;
        int      m;
        int      k;
        acc = 0;
        if (restart) begin
            foreach (history[j]) history[j] = '0;
        end
        for (k = 0; k < NUM_TAPS; k++) begin
            m = (k < NUM_TAPS - 1 - k) ? k : NUM_TAPS - 1 - k;
            s = (k == 0) ? x : history[k-1];
            acc += longint'(coef_shadow[m]) * longint'(s);
        end
        for (k = NUM_TAPS - 2; k > 0; k--) history[k] = history[k-1];
        history[0] = x;
        return t_sample'(acc[30:15]);
    endfunction

    // mostly full-range values, with the extremes picked often
    function automatic t_sample random_sample();
        case ($urandom_range(15))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic push_request(t_sample sample, logic restart);
        sample_requests.push_back('{sample: sample, restart: restart});
        requests_open++;
    endtask

    // wait until every request is accepted and every filtered sample has come back
    task automatic wait_drained();
        while (requests_open != 0 || filtered_expected.size() != 0) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle
    task automatic write_coef(int idx, logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx << ADDR_LSB);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        coef_shadow[idx] = t_sample'(value[15:0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // load a whole coefficient set; upper word bits are junk and must be dropped
    task automatic program_coefs(t_coef_set set);
        logic [DATA_W-1:0] word;
        for (int i = 0; i < NCOEF; i++) begin
            word = $urandom;
            case (set)
                CS_DEFAULT:   word[15:0] = COEF_RESET[i];
                CS_ALL_MIN:   word[15:0] = 16'h8000;
                CS_ALL_MAX:   word[15:0] = 16'h7fff;
                CS_ALTERNATE: word[15:0] = (i % 2 == 0) ? 16'h8000 : 16'h7fff;
                default:      ;
            endcase
            write_coef(i, word);
        end
    endtask

    task automatic run_random(int n, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(negedge i_clk);
        repeat (n) push_request(random_sample(), $urandom_range(47) == 0);
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_fir_request item;
        if (!i_in_valid || req_taken) begin
            if (i_rst_n && sample_requests.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                item = sample_requests.pop_front();
                i_sample_in <= item.sample;
                i_restart   <= item.restart;
                i_in_valid  <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (holds_done != holds_asked) begin
            hold_left  = HOLD_CYCLES;
            holds_done = holds_done + 1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_sample want;
        req_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                filtered_expected.push_back(fir_filter_next(i_sample_in, i_restart));
                requests_open--;
            end
            if (o_out_valid && i_out_ready) begin
                if (filtered_expected.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected sample_out, expected none, got %0d",
                             $time, o_sample_out);
                end else begin
                    want = filtered_expected.pop_front();
                    if (o_sample_out !== want) begin
                        mismatch_count++;
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want, o_sample_out);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default coefficients, extremes, restart mid-stream
        @(negedge i_clk);
        push_request(16'sh7fff, 1'b1);
        push_request(16'sh8000, 1'b0);
        push_request(16'sh7fff, 1'b0);
        push_request(16'sh0000, 1'b0);
        push_request(16'shffff, 1'b0);
        push_request(16'sh0001, 1'b0);
        push_request(16'sh8000, 1'b1);
        push_request(16'sh8000, 1'b0);
        push_request(16'sh3039, 1'b0);
        push_request(16'shffff, 1'b1);
        wait_drained();

        // directed: most negative coefficients and samples, the sum wraps
        program_coefs(CS_ALL_MIN);
        @(negedge i_clk);
        push_request(16'sh8000, 1'b1);
        repeat (12) push_request(16'sh8000, 1'b0);
        wait_drained();

        // sender light, receiver heavy, with one long receiver hold-off
        program_coefs(CS_RANDOM);
        run_random(RAND_PHASE_ITEMS, 11, 66);
        holds_asked++;
        wait_drained();
        program_coefs(CS_ALL_MAX);
        run_random(RAND_PHASE_ITEMS, 11, 66);
        wait_drained();

        // sender heavy, receiver light
        program_coefs(CS_ALTERNATE);
        run_random(RAND_PHASE_ITEMS, 66, 11);
        wait_drained();
        program_coefs(CS_RANDOM);
        run_random(RAND_PHASE_ITEMS, 66, 11);
        wait_drained();

        // full rate both sides
        program_coefs(CS_DEFAULT);
        run_random(RAND_PHASE_ITEMS, 0, 0);
        wait_drained();
        program_coefs(CS_RANDOM);
        run_random(RAND_PHASE_ITEMS, 0, 0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
